/* design/lce_pkg.sv */
// ----------------------------------------------------------------------------
// lce_pkg
// Types and codes shared by the led connector effect engine files.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int COLOUR_W = 8;
  localparam int REG_W    = 16;
  localparam int SEL_W    = 4;
  localparam int PIX_W    = 7;

  // stored connector mode
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_DIM   = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_FLASH = 2'd3
  } mode_t;

  // requested mode on a set beat
  typedef enum logic [1:0] {
    SET_DIM    = 2'd0,
    SET_FIXED  = 2'd1,
    SET_BLINK  = 2'd2,
    SET_FIXED2 = 2'd3
  } set_mode_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SET  = 1'b1
  } req_t;

  typedef enum logic {
    REG_BLINK_RELOAD  = 1'b0,
    REG_DIMMER_RELOAD = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    mode_t               mode;
    logic                refresh;
  } entry_t;

  typedef struct packed {
    logic                req_type;
    logic [SEL_W-1:0]    conn_select;
    logic [COLOUR_W-1:0] set_red;
    logic [COLOUR_W-1:0] set_green;
    logic [COLOUR_W-1:0] set_blue;
    logic [1:0]          set_mode;
  } req_item_t;

  typedef struct packed {
    logic [SEL_W-1:0]    conn_out;
    logic [PIX_W-1:0]    first_pixel;
    logic [COLOUR_W-1:0] out_red;
    logic [COLOUR_W-1:0] out_green;
    logic [COLOUR_W-1:0] out_blue;
    logic                frame_done;
  } res_item_t;

endpackage

/* design/lce_chan_if.sv */
// ----------------------------------------------------------------------------
// lce_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lce_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/lce_ram.sv */
// ----------------------------------------------------------------------------
// lce_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* design/led_connector_effect_engine.sv */
// ----------------------------------------------------------------------------
// led_connector_effect_engine
// Connector colour table with dimmer ramp and blink effects; a tick that
// steps the dimmer walks the table and emits one beat per updated connector.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  in_chan   in   tick or set request (req_item_t)
//  out_chan  out  connector colour result (res_item_t)
//  cfg_*     in   register write, no handshake
//
//  a set or a plain tick is handled in ST_IDLE; a tick that steps the dimmer
//  runs a pass that reads each connector from the single table read port
//  (ST_READ), evaluates it (ST_EVAL), and ends with a flush (ST_FLUSH).
//  a new request is taken only when the pass is over. output stalls hold the
//  pass at the next emitting connector. reset is synchronous; table entries
//  read as zero until first written.
module led_connector_effect_engine #(
  parameter int CONNECTORS      = 9,
  parameter int PIXELS_PER_CONN = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lce_chan_if.sink                 in_chan,
  lce_chan_if.source               out_chan,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [lce_pkg::REG_W-1:0] cfg_wdata
);
  import lce_pkg::*;

  localparam int IW = (CONNECTORS > 1) ? $clog2(CONNECTORS) : 1;
  localparam int EW = $bits(entry_t);
  localparam logic [IW-1:0]    LAST_IDX = IW'(CONNECTORS - 1);
  localparam logic [SEL_W:0]   CONN_LIM = (SEL_W + 1)'(CONNECTORS);
  localparam logic [PIX_W+3:0] PIX_MUL  = (PIX_W + 4)'(PIXELS_PER_CONN);

  state_t          state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [REG_W-1:0] blink_reload_r, dimmer_reload_r;
  logic [REG_W-1:0] blink_cnt_r, blink_cnt_nxt;
  logic [REG_W-1:0] dim_cnt_r, dim_cnt_nxt;
  logic            blink_phase_r, blink_phase_nxt;
  logic            blink_pend_r, blink_pend_nxt;
  logic [7:0]      dim_level_r, dim_level_nxt;
  logic            dim_rising_r, dim_rising_nxt;
  logic [CONNECTORS-1:0] valid_r, valid_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  res_item_t       pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_item_t       out_data_r, out_data_nxt;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [EW-1:0]   ram_rdata;

  req_item_t       req;
  entry_t          ent;
  logic            in_acc, out_free, emit, proceed;
  logic [15:0]     prod_r, prod_g, prod_b;
  logic [PIX_W+3:0] pix_full;
  res_item_t       cand;

  lce_ram #(
    .WIDTH (EW),
    .DEPTH (CONNECTORS),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign req           = in_chan.data;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign out_free       = !out_valid_r || out_chan.ready;

  // unwritten entries read as the reset value
  always_comb begin
    ent = entry_t'(ram_rdata);
    if (!valid_r[idx_r]) begin
      ent = entry_t'('0);
    end
  end

  assign prod_r   = 16'(ent.red) * 16'(dim_level_r);
  assign prod_g   = 16'(ent.green) * 16'(dim_level_r);
  assign prod_b   = 16'(ent.blue) * 16'(dim_level_r);
  assign pix_full = (PIX_W + 4)'(idx_r) * PIX_MUL;

  always_comb begin
    cand             = '0;
    cand.conn_out    = SEL_W'(idx_r);
    cand.first_pixel = pix_full[PIX_W-1:0];
    emit             = 1'b0;
    if (ent.refresh) begin
      emit          = 1'b1;
      cand.out_red   = ent.red;
      cand.out_green = ent.green;
      cand.out_blue  = ent.blue;
    end else if (ent.mode == MODE_DIM) begin
      emit          = 1'b1;
      cand.out_red   = prod_r[15:8];
      cand.out_green = prod_g[15:8];
      cand.out_blue  = prod_b[15:8];
    end else if (ent.mode == MODE_FLASH && blink_pend_r) begin
      emit = 1'b1;
      if (blink_phase_r) begin
        cand.out_red   = ent.red;
        cand.out_green = ent.green;
        cand.out_blue  = ent.blue;
      end
    end
  end

  // a found result waits in pend until the next one shows it is not last
  assign proceed = !emit || !pend_valid_r || out_free;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    blink_cnt_nxt   = blink_cnt_r;
    dim_cnt_nxt     = dim_cnt_r;
    blink_phase_nxt = blink_phase_r;
    blink_pend_nxt  = blink_pend_r;
    dim_level_nxt   = dim_level_r;
    dim_rising_nxt  = dim_rising_r;
    valid_nxt       = valid_r;
    pend_valid_nxt  = pend_valid_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = ent;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (req.req_type == REQ_SET) begin
            if ({1'b0, req.conn_select} < CONN_LIM) begin
              ram_we          = 1'b1;
              ram_waddr       = req.conn_select[IW-1:0];
              ram_wdata.red   = req.set_red;
              ram_wdata.green = req.set_green;
              ram_wdata.blue  = req.set_blue;
              case (set_mode_t'(req.set_mode))
                SET_DIM: begin
                  ram_wdata.mode    = MODE_DIM;
                  ram_wdata.refresh = 1'b0;
                end
                SET_BLINK: begin
                  ram_wdata.mode    = MODE_FLASH;
                  ram_wdata.refresh = 1'b0;
                end
                default: begin
                  ram_wdata.mode    = MODE_FIXED;
                  ram_wdata.refresh = 1'b1;
                end
              endcase
              valid_nxt[req.conn_select[IW-1:0]] = 1'b1;
            end
          end else begin
            if (blink_cnt_r != '0) begin
              blink_cnt_nxt = blink_cnt_r - 1'b1;
            end else begin
              blink_cnt_nxt   = blink_reload_r;
              blink_pend_nxt  = 1'b1;
              blink_phase_nxt = !blink_phase_r;
            end
            if (dim_cnt_r != '0) begin
              dim_cnt_nxt = dim_cnt_r - 1'b1;
            end else begin
              dim_cnt_nxt = dimmer_reload_r;
              if (dim_rising_r) begin
                if (dim_level_r != 8'hff) begin
                  dim_level_nxt = dim_level_r + 1'b1;
                end else begin
                  dim_rising_nxt = 1'b0;
                end
              end else begin
                if (dim_level_r != 8'h00) begin
                  dim_level_nxt = dim_level_r - 1'b1;
                end else begin
                  dim_rising_nxt = 1'b1;
                end
              end
              idx_nxt   = '0;
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (proceed) begin
          if (ent.refresh) begin
            ram_we            = 1'b1;
            ram_wdata.refresh = 1'b0;
          end
          if (emit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = cand;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt            = pend_r;
            out_data_nxt.frame_done = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          blink_pend_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      idx_r           <= '0;
      blink_reload_r  <= REG_W'(500);
      dimmer_reload_r <= REG_W'(3);
      blink_cnt_r     <= '0;
      dim_cnt_r       <= '0;
      blink_phase_r   <= 1'b0;
      blink_pend_r    <= 1'b0;
      dim_level_r     <= '0;
      dim_rising_r    <= 1'b0;
      valid_r         <= '0;
      pend_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
      dim_cnt_r     <= dim_cnt_nxt;
      blink_phase_r <= blink_phase_nxt;
      blink_pend_r  <= blink_pend_nxt;
      dim_level_r   <= dim_level_nxt;
      dim_rising_r  <= dim_rising_nxt;
      valid_r       <= valid_nxt;
      pend_valid_r  <= pend_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLINK_RELOAD:  blink_reload_r  <= cfg_wdata;
          REG_DIMMER_RELOAD: dimmer_reload_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
